// File: src/rpt_pkg.sv
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types and constants for the reference-counted peer table.
// ----------------------------------------------------------------------------
package rpt_pkg;

   localparam int ADDR_W         = 48;
   localparam int MAC_W          = 8;
   localparam int REF_W          = 8;
   localparam int OP_W           = 3;
   localparam int PEER_SLOTS_DEF = 16;

   localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

   // Operation codes
   localparam logic [OP_W-1:0] OP_ESTABLISH = 3'd0;
   localparam logic [OP_W-1:0] OP_TERMINATE = 3'd1;
   localparam logic [OP_W-1:0] OP_CLASSIFY  = 3'd2;
   localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd4;

   // One table entry as held in the slot memory
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [MAC_W-1:0]  mac_id;
      logic [REF_W-1:0]  refcount;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   // Outcome of a table search
   typedef struct packed {
      logic             hit;
      logic             free_ok;
      logic [MAC_W-1:0] mac_id;
      logic [REF_W-1:0] refcount;
   } scan_res_type;

endpackage

// File: src/rpt_ram.sv
// ----------------------------------------------------------------------------
// rpt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rpt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/rpt_scan.sv
// ----------------------------------------------------------------------------
// rpt_scan
// Walks the slot memory one entry a cycle, matches the key against valid
// slots and notes the lowest free slot.
// ----------------------------------------------------------------------------
module rpt_scan #(
   parameter int PEER_SLOTS = rpt_pkg::PEER_SLOTS_DEF,
   parameter int IDX_W      = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [rpt_pkg::ADDR_W-1:0] key,
   input  logic [PEER_SLOTS-1:0]     slot_valid,
   output logic                      rd_en,
   output logic [IDX_W-1:0]          rd_addr,
   input  rpt_pkg::slot_type         rd_data,
   output logic                      done,
   output rpt_pkg::scan_res_type     res,
   output logic [IDX_W-1:0]          hit_idx,
   output logic [IDX_W-1:0]          free_idx
);
   import rpt_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PEER_SLOTS - 1);

   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             cmp_last_ff, cmp_last_in;
   logic             done_ff, done_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in;
   logic [MAC_W-1:0] mac_ff, mac_in;
   logic [REF_W-1:0] cnt_ff, cnt_in;
   logic             free_ok_ff, free_ok_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   always_comb begin
      busy_in      = busy_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = busy_ff;
      cmp_idx_in   = rd_idx_ff;
      cmp_last_in  = busy_ff && (rd_idx_ff == LAST_IDX);
      done_in      = cmp_vld_ff && cmp_last_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      mac_in       = mac_ff;
      cnt_in       = cnt_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;

      if (start) begin
         busy_in    = 1'b1;
         rd_idx_in  = '0;
         found_in   = 1'b0;
         free_ok_in = 1'b0;
      end else if (busy_ff) begin
         // note the lowest free slot as its read goes out
         if (!slot_valid[rd_idx_ff] && !free_ok_ff) begin
            free_ok_in  = 1'b1;
            free_idx_in = rd_idx_ff;
         end
         if (rd_idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end else begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
      end

      if (cmp_vld_ff && !found_ff && slot_valid[cmp_idx_ff] && (rd_data.addr == key)) begin
         found_in     = 1'b1;
         found_idx_in = cmp_idx_ff;
         mac_in       = rd_data.mac_id;
         cnt_in       = rd_data.refcount;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         cmp_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         cmp_vld_ff <= cmp_vld_in;
         done_ff    <= done_in;
      end
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      cmp_last_ff  <= cmp_last_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      mac_ff       <= mac_in;
      cnt_ff       <= cnt_in;
      free_ok_ff   <= free_ok_in;
      free_idx_ff  <= free_idx_in;
   end

   assign rd_en        = busy_ff;
   assign rd_addr      = rd_idx_ff;
   assign done         = done_ff;
   assign res.hit      = found_ff;
   assign res.free_ok  = free_ok_ff;
   assign res.mac_id   = mac_ff;
   assign res.refcount = cnt_ff;
   assign hit_idx      = found_idx_ff;
   assign free_idx     = free_idx_ff;

endmodule

// File: src/refcounted_peer_table_classifier.sv
// ----------------------------------------------------------------------------
// refcounted_peer_table_classifier
// Peer table with per-entry reference counts and a NAN frame classifier.
// ----------------------------------------------------------------------------
// Each item is establish, terminate, classify, lookup or clear-all, and gives
// exactly one result item. Entries (address, MAC id, count) live in a
// single-port-read synchronous RAM; valid bits are flip-flops. Establish,
// terminate, classify and lookup run a search that reads one slot a cycle,
// then an update state in which establish and terminate write back the
// matched slot, or a free one for a new peer. Clear-all and unknown codes
// skip the search. A new item is accepted from the cycle after the
// previous result is loaded, even while that result waits.
module refcounted_peer_table_classifier #(
   parameter int PEER_SLOTS = rpt_pkg::PEER_SLOTS_DEF,
   parameter int IDX_W      = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1,
   parameter int CNT_W      = $clog2(PEER_SLOTS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [rpt_pkg::OP_W-1:0]   req_op,
   input  logic [rpt_pkg::ADDR_W-1:0] req_peer_addr,
   input  logic [rpt_pkg::ADDR_W-1:0] req_frame_bssid,
   input  logic [rpt_pkg::MAC_W-1:0]  req_peer_mac_id,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_hit,
   output logic                       rsp_is_nan,
   output logic [rpt_pkg::MAC_W-1:0]  rsp_found_mac_id,
   output logic [rpt_pkg::REF_W-1:0]  rsp_found_count,
   output logic                       rsp_first_link,
   output logic                       rsp_link_freed,
   output logic                       rsp_table_full,
   output logic [CNT_W-1:0]           rsp_link_count
);
   import rpt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // captured item
   logic [OP_W-1:0]   op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] bssid_ff;
   logic [MAC_W-1:0]  mac_ff;

   // table state outside the RAM
   logic [PEER_SLOTS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic                  enabled_ff, enabled_in;
   logic [ADDR_W-1:0]     cluster_ff, cluster_in;

   // result register
   logic              rsp_valid_ff;
   logic              hit_ff, hit_in;
   logic              nan_ff, nan_in;
   logic [MAC_W-1:0]  fmac_ff, fmac_in;
   logic [REF_W-1:0]  fcnt_ff, fcnt_in;
   logic              first_ff, first_in;
   logic              freed_ff, freed_in;
   logic              full_ff, full_in;

   logic             req_fire, needs_scan, scan_start, scan_done, fire;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr, hit_idx, free_idx;
   slot_type         rd_data;
   scan_res_type     scan_res;
   logic             wr_req;
   logic [IDX_W-1:0] wr_addr;
   slot_type         wr_data;
   logic [REF_W-1:0] cnt_next;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign needs_scan = (req_op == OP_ESTABLISH) || (req_op == OP_TERMINATE) ||
                       (req_op == OP_CLASSIFY) || (req_op == OP_LOOKUP);
   assign scan_start = req_fire && needs_scan;
   // load the result only once the previous one has left
   assign fire = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   rpt_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(PEER_SLOTS),
      .AW   (IDX_W)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (fire && wr_req),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   rpt_scan #(
      .PEER_SLOTS(PEER_SLOTS),
      .IDX_W     (IDX_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .key       (addr_ff),
      .slot_valid(valid_ff),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .done      (scan_done),
      .res       (scan_res),
      .hit_idx   (hit_idx),
      .free_idx  (free_idx)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = needs_scan ? ST_SCAN : ST_UPDATE;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Decide the result and the slot write-back from the search outcome.
   always_comb begin
      valid_in   = valid_ff;
      total_in   = total_ff;
      enabled_in = enabled_ff;
      cluster_in = cluster_ff;
      hit_in     = 1'b0;
      nan_in     = 1'b0;
      fmac_in    = '0;
      fcnt_in    = '0;
      first_in   = 1'b0;
      freed_in   = 1'b0;
      full_in    = 1'b0;
      wr_req     = 1'b0;
      wr_addr    = hit_idx;
      wr_data    = '{addr: addr_ff, mac_id: scan_res.mac_id, refcount: scan_res.refcount};
      cnt_next   = scan_res.refcount;

      case (op_ff)
         OP_ESTABLISH: begin
            cluster_in = bssid_ff;
            enabled_in = 1'b1;
            hit_in     = scan_res.hit;
            if (scan_res.hit) begin
               cnt_next = (scan_res.refcount == REF_MAX) ? REF_MAX
                                                         : scan_res.refcount + 1'b1;
               wr_req   = 1'b1;
               wr_data  = '{addr: addr_ff, mac_id: mac_ff, refcount: cnt_next};
               fmac_in  = mac_ff;
               fcnt_in  = cnt_next;
            end else if (scan_res.free_ok) begin
               cnt_next           = REF_W'(1);
               wr_req             = 1'b1;
               wr_addr            = free_idx;
               wr_data            = '{addr: addr_ff, mac_id: mac_ff, refcount: cnt_next};
               valid_in[free_idx] = 1'b1;
               total_in           = total_ff + 1'b1;
               first_in           = 1'b1;
               fmac_in            = mac_ff;
               fcnt_in            = cnt_next;
            end else begin
               full_in = 1'b1;
            end
         end
         OP_TERMINATE: begin
            hit_in = scan_res.hit;
            if (scan_res.hit) begin
               cnt_next = (scan_res.refcount != '0) ? scan_res.refcount - 1'b1 : '0;
               wr_req   = 1'b1;
               wr_data  = '{addr: addr_ff, mac_id: scan_res.mac_id, refcount: cnt_next};
               fmac_in  = scan_res.mac_id;
               fcnt_in  = cnt_next;
               if (cnt_next == '0) begin
                  // drop the entry
                  valid_in[hit_idx] = 1'b0;
                  total_in          = (total_ff != '0) ? total_ff - 1'b1 : '0;
                  freed_in          = 1'b1;
               end
            end
         end
         OP_CLASSIFY: begin
            hit_in = scan_res.hit;
            if (scan_res.hit) begin
               fmac_in = scan_res.mac_id;
               fcnt_in = scan_res.refcount;
            end
            nan_in = enabled_ff && (total_ff != '0) &&
                     ((bssid_ff == cluster_ff) || scan_res.hit);
         end
         OP_LOOKUP: begin
            hit_in = scan_res.hit;
            if (scan_res.hit) begin
               fmac_in = scan_res.mac_id;
               fcnt_in = scan_res.refcount;
            end
         end
         OP_CLEAR_ALL: begin
            valid_in   = '0;
            total_in   = '0;
            enabled_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         total_ff     <= '0;
         enabled_ff   <= 1'b0;
         cluster_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fire) begin
            valid_ff     <= valid_in;
            total_ff     <= total_in;
            enabled_ff   <= enabled_in;
            cluster_ff   <= cluster_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         op_ff    <= req_op;
         addr_ff  <= req_peer_addr;
         bssid_ff <= req_frame_bssid;
         mac_ff   <= req_peer_mac_id;
      end
      if (fire) begin
         hit_ff   <= hit_in;
         nan_ff   <= nan_in;
         fmac_ff  <= fmac_in;
         fcnt_ff  <= fcnt_in;
         first_ff <= first_in;
         freed_ff <= freed_in;
         full_ff  <= full_in;
      end
   end

   logic [CNT_W-1:0] link_count_ff;

   always_ff @(posedge clock) begin
      if (fire) begin
         link_count_ff <= total_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_is_nan       = nan_ff;
   assign rsp_found_mac_id = fmac_ff;
   assign rsp_found_count  = fcnt_ff;
   assign rsp_first_link   = first_ff;
   assign rsp_link_freed   = freed_ff;
   assign rsp_table_full   = full_ff;
   assign rsp_link_count   = link_count_ff;

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reference-counted peer table classifier.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the empty table, the field
// extremes, every opcode, undefined codes, unknown-peer terminates and clear.
// Random traffic follows: a forced table fill and a count saturation run,
// then mostly bursts over a small address pool so that peers hit, fill the
// table and drain. Noise items are mixed in. Every request goes through a
// local model of the table, and each response is compared field by field in
// order. Both channels idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb;
   import rpt_pkg::*;

   localparam int SLOTS       = PEER_SLOTS_DEF;
   localparam int LC_W        = $clog2(SLOTS + 1);
   localparam int TOTAL_ITEMS = 1750;
   localparam int CALM_FROM   = TOTAL_ITEMS - 150;
   localparam int POOL_SIZE   = 24;
   localparam int DRAIN_WAIT  = 40;
   localparam int STALL_LIMIT = 2000;
   localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] bssid;
      logic [MAC_W-1:0]  mac;
   } peer_req_type;

   typedef struct packed {
      logic             hit;
      logic             is_nan;
      logic [MAC_W-1:0] mac;
      logic [REF_W-1:0] count;
      logic             first;
      logic             freed;
      logic             full;
      logic [LC_W-1:0]  link_count;
   } peer_rsp_type;

   typedef struct packed {
      peer_req_type req;
      logic         typed;
      peer_rsp_type want;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_op;
   logic [ADDR_W-1:0]   req_peer_addr;
   logic [ADDR_W-1:0]   req_frame_bssid;
   logic [MAC_W-1:0]    req_peer_mac_id;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_hit;
   logic                rsp_is_nan;
   logic [MAC_W-1:0]    rsp_found_mac_id;
   logic [REF_W-1:0]    rsp_found_count;
   logic                rsp_first_link;
   logic                rsp_link_freed;
   logic                rsp_table_full;
   logic [LC_W-1:0]     rsp_link_count;

   // model of the peer table
   logic                tbl_valid [SLOTS];
   logic                tbl_est   [SLOTS];
   logic [ADDR_W-1:0]   tbl_addr  [SLOTS];
   logic [MAC_W-1:0]    tbl_mac   [SLOTS];
   logic [REF_W-1:0]    tbl_cnt   [SLOTS];
   int                  tbl_total;
   logic                nan_on;
   logic [ADDR_W-1:0]   cluster;

   peer_rsp_type        pending_rsp [$];
   dir_row_type         dir_rows [$];
   logic [ADDR_W-1:0]   addr_pool [POOL_SIZE];
   logic [ADDR_W-1:0]   bssid_pool [3];

   int                  n_sent;
   int                  n_checked;
   int                  n_full;
   int                  n_sat;
   int                  n_freed;
   int                  mismatches;
   int                  idle_cycles;
   int                  stall_left;
   bit                  calm;

   refcounted_peer_table_classifier dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_peer_addr    (req_peer_addr),
      .req_frame_bssid  (req_frame_bssid),
      .req_peer_mac_id  (req_peer_mac_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_is_nan       (rsp_is_nan),
      .rsp_found_mac_id (rsp_found_mac_id),
      .rsp_found_count  (rsp_found_count),
      .rsp_first_link   (rsp_first_link),
      .rsp_link_freed   (rsp_link_freed),
      .rsp_table_full   (rsp_table_full),
      .rsp_link_count   (rsp_link_count)
   );

   always #2 clock = ~clock;

   function automatic logic [ADDR_W-1:0] rand_addr();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[ADDR_W-1:0];
   endfunction

   function automatic logic [MAC_W-1:0] rand_mac();
      return MAC_W'($urandom_range(0, 255));
   endfunction

   function automatic peer_req_type mk_req(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                           logic [ADDR_W-1:0] bssid, logic [MAC_W-1:0] mac);
      peer_req_type r;
      r.op    = op;
      r.addr  = addr;
      r.bssid = bssid;
      r.mac   = mac;
      return r;
   endfunction

   function automatic peer_rsp_type mk_rsp(logic hit, logic is_nan, logic [MAC_W-1:0] mac,
                                           logic [REF_W-1:0] count, logic first, logic freed,
                                           logic full, logic [LC_W-1:0] link_count);
      peer_rsp_type e;
      e.hit        = hit;
      e.is_nan     = is_nan;
      e.mac        = mac;
      e.count      = count;
      e.first      = first;
      e.freed      = freed;
      e.full       = full;
      e.link_count = link_count;
      return e;
   endfunction

   // Apply one request to the table model and return the response it gives.
   function automatic peer_rsp_type table_update(peer_req_type r);
      peer_rsp_type e;
      int           s;
      int           f;
      e = '0;
      s = -1;
      f = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (s < 0 && tbl_valid[i] && tbl_addr[i] == r.addr) s = i;
      end
      e.hit = (s >= 0);
      case (r.op)
         OP_ESTABLISH: begin
            cluster = r.bssid;
            nan_on  = 1'b1;
            if (s < 0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (f < 0 && !tbl_valid[i]) f = i;
               end
               if (f < 0) begin
                  e.full = 1'b1;
               end else begin
                  s            = f;
                  tbl_valid[s] = 1'b1;
                  tbl_addr[s]  = r.addr;
                  tbl_cnt[s]   = '0;
                  tbl_total++;
                  e.first      = 1'b1;
               end
            end
            if (s >= 0) begin
               tbl_mac[s] = r.mac;
               tbl_est[s] = 1'b1;
               if (tbl_cnt[s] != REF_MAX) tbl_cnt[s] = tbl_cnt[s] + 1'b1;
               e.mac   = tbl_mac[s];
               e.count = tbl_cnt[s];
            end
         end
         OP_TERMINATE: begin
            if (s >= 0) begin
               if (tbl_cnt[s] != '0) tbl_cnt[s] = tbl_cnt[s] - 1'b1;
               e.mac   = tbl_mac[s];
               e.count = tbl_cnt[s];
               if (tbl_cnt[s] == '0) begin
                  tbl_valid[s] = 1'b0;
                  tbl_est[s]   = 1'b0;
                  if (tbl_total > 0) tbl_total--;
                  e.freed = 1'b1;
               end
            end
         end
         OP_CLASSIFY: begin
            if (s >= 0) begin
               e.mac   = tbl_mac[s];
               e.count = tbl_cnt[s];
            end
            if (nan_on && tbl_total != 0) begin
               if (r.bssid == cluster) e.is_nan = 1'b1;
               else if (s >= 0 && tbl_est[s]) e.is_nan = 1'b1;
            end
         end
         OP_LOOKUP: begin
            if (s >= 0) begin
               e.mac   = tbl_mac[s];
               e.count = tbl_cnt[s];
            end
         end
         OP_CLEAR_ALL: begin
            for (int i = 0; i < SLOTS; i++) begin
               tbl_valid[i] = 1'b0;
               tbl_est[i]   = 1'b0;
            end
            tbl_total = 0;
            nan_on    = 1'b0;
            e.hit     = 1'b0;
         end
         default: begin
            e.hit = 1'b0;
         end
      endcase
      e.link_count = tbl_total[LC_W-1:0];
      return e;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Present one item and hold it until accepted.
   task automatic drive_req(peer_req_type r);
      calm = (n_sent >= CALM_FROM);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= r.op;
      req_peer_addr   <= r.addr;
      req_frame_bssid <= r.bssid;
      req_peer_mac_id <= r.mac;
      do @(posedge clock); while (!req_ready);
      n_sent++;
   endtask

   task automatic send_pred(peer_req_type r);
      drive_req(r);
      pending_rsp.push_back(table_update(r));
   endtask

   // Response side: random backpressure bursts, none once the run calms down.
   always @(posedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      peer_rsp_type want;
      if (!reset && ((req_valid && req_ready) || (rsp_valid && rsp_ready)))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("hit", 64'(want.hit), 64'(rsp_hit));
            check_field("is_nan", 64'(want.is_nan), 64'(rsp_is_nan));
            check_field("found_mac_id", 64'(want.mac), 64'(rsp_found_mac_id));
            check_field("found_count", 64'(want.count), 64'(rsp_found_count));
            check_field("first_link", 64'(want.first), 64'(rsp_first_link));
            check_field("link_freed", 64'(want.freed), 64'(rsp_link_freed));
            check_field("table_full", 64'(want.full), 64'(rsp_table_full));
            check_field("link_count", 64'(want.link_count), 64'(rsp_link_count));
            n_checked++;
            if (rsp_table_full) n_full++;
            if (rsp_link_freed) n_freed++;
            if (rsp_found_count == REF_MAX) n_sat++;
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("refcounted_peer_table_classifier regression: fail");
      $finish;
   end

   initial begin
      peer_req_type r;
      peer_rsp_type e;
      dir_row_type  row;
      int           pick;
      int           len;
      int           base;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_op          <= OP_LOOKUP;
      req_peer_addr   <= '0;
      req_frame_bssid <= '0;
      req_peer_mac_id <= '0;
      rsp_ready       <= 1'b0;
      stall_left       = 0;
      idle_cycles      = 0;
      calm             = 0;
      n_sent           = 0;
      n_checked        = 0;
      n_full           = 0;
      n_sat            = 0;
      n_freed          = 0;
      mismatches       = 0;
      tbl_total        = 0;
      nan_on           = 1'b0;
      cluster          = '0;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_est[i]   = 1'b0;
         tbl_addr[i]  = '0;
         tbl_mac[i]   = '0;
         tbl_cnt[i]   = '0;
      end
      for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = rand_addr();
      for (int i = 0; i < 3; i++) bssid_pool[i] = rand_addr();

      // directed rows: typed responses where they follow at a glance
      dir_rows.push_back('{mk_req(OP_LOOKUP, '0, '0, '0), 1'b1,
                           mk_rsp(1'b0, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0, LC_W'(0))});
      dir_rows.push_back('{mk_req(OP_CLASSIFY, '0, '0, '0), 1'b1,
                           mk_rsp(1'b0, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0, LC_W'(0))});
      dir_rows.push_back('{mk_req(OP_TERMINATE, ADDR_ONES, ADDR_ONES, 8'hFF), 1'b1,
                           mk_rsp(1'b0, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0, LC_W'(0))});
      dir_rows.push_back('{mk_req(OP_ESTABLISH, ADDR_ONES, ADDR_ONES, 8'hFF), 1'b1,
                           mk_rsp(1'b0, 1'b0, 8'hFF, 8'd1, 1'b1, 1'b0, 1'b0, LC_W'(1))});
      dir_rows.push_back('{mk_req(OP_ESTABLISH, '0, '0, 8'h00), 1'b1,
                           mk_rsp(1'b0, 1'b0, 8'h00, 8'd1, 1'b1, 1'b0, 1'b0, LC_W'(2))});
      dir_rows.push_back('{mk_req(OP_ESTABLISH, ADDR_ONES, '0, 8'h5A), 1'b1,
                           mk_rsp(1'b1, 1'b0, 8'h5A, 8'd2, 1'b0, 1'b0, 1'b0, LC_W'(2))});
      // address 3 alone decides; transmitter unknown
      dir_rows.push_back('{mk_req(OP_CLASSIFY, 48'h1234_5678_9ABC, '0, 8'h00), 1'b1,
                           mk_rsp(1'b0, 1'b1, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0, LC_W'(2))});
      dir_rows.push_back('{mk_req(OP_CLASSIFY, ADDR_ONES, 48'hA5A5_A5A5_A5A5, 8'h00),
                           1'b0, '0});
      dir_rows.push_back('{mk_req(OP_LOOKUP, ADDR_ONES, '0, 8'h00), 1'b0, '0});
      dir_rows.push_back('{mk_req(OP_TERMINATE, ADDR_ONES, '0, 8'h00), 1'b0, '0});
      dir_rows.push_back('{mk_req(OP_TERMINATE, ADDR_ONES, '0, 8'h00), 1'b0, '0});
      dir_rows.push_back('{mk_req(OP_CLASSIFY, ADDR_ONES, 48'h5A5A_5A5A_5A5A, 8'h00),
                           1'b0, '0});
      // undefined codes leave everything but the link count at zero
      dir_rows.push_back('{mk_req(3'd5, ADDR_ONES, ADDR_ONES, 8'hFF), 1'b1,
                           mk_rsp(1'b0, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0, LC_W'(1))});
      dir_rows.push_back('{mk_req(3'd6, '0, '0, 8'h00), 1'b1,
                           mk_rsp(1'b0, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0, LC_W'(1))});
      dir_rows.push_back('{mk_req(3'd7, '0, ADDR_ONES, 8'hFF), 1'b1,
                           mk_rsp(1'b0, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0, LC_W'(1))});
      dir_rows.push_back('{mk_req(OP_CLEAR_ALL, '0, '0, 8'h00), 1'b1,
                           mk_rsp(1'b0, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0, LC_W'(0))});
      dir_rows.push_back('{mk_req(OP_CLASSIFY, '0, '0, 8'h00), 1'b1,
                           mk_rsp(1'b0, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0, LC_W'(0))});
      dir_rows.push_back('{mk_req(OP_LOOKUP, '0, '0, 8'h00), 1'b1,
                           mk_rsp(1'b0, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0, LC_W'(0))});
      dir_rows.push_back('{mk_req(OP_ESTABLISH, '0, 48'h0123_4567_89AB, 8'h80), 1'b0, '0});
      dir_rows.push_back('{mk_req(OP_TERMINATE, '0, '0, 8'h00), 1'b0, '0});
      dir_rows.push_back('{mk_req(OP_TERMINATE, '0, '0, 8'h00), 1'b1,
                           mk_rsp(1'b0, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0, LC_W'(0))});
      // bssid matches but no link remains
      dir_rows.push_back('{mk_req(OP_CLASSIFY, '0, 48'h0123_4567_89AB, 8'h00), 1'b1,
                           mk_rsp(1'b0, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0, LC_W'(0))});

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         drive_req(row.req);
         e = table_update(row.req);
         if (row.typed) e = row.want;
         pending_rsp.push_back(e);
      end

      // fill the table past its size: the seventeenth new peer is refused
      send_pred(mk_req(OP_CLEAR_ALL, '0, '0, '0));
      for (int k = 0; k < SLOTS + 2; k++)
         send_pred(mk_req(OP_ESTABLISH, addr_pool[k], bssid_pool[0], rand_mac()));

      // drive one count into saturation, then back off a little
      pick = $urandom_range(0, SLOTS - 1);
      for (int k = 0; k < 258; k++)
         send_pred(mk_req(OP_ESTABLISH, addr_pool[pick], bssid_pool[1], rand_mac()));
      repeat (3) send_pred(mk_req(OP_TERMINATE, addr_pool[pick], rand_addr(), '0));

      while (n_sent < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            len = $urandom_range(8, 30);
            for (int k = 0; k < len; k++) begin
               pick = $urandom_range(0, 99);
               if (pick < 35)      r.op = OP_ESTABLISH;
               else if (pick < 65) r.op = OP_TERMINATE;
               else if (pick < 85) r.op = OP_CLASSIFY;
               else if (pick < 95) r.op = OP_LOOKUP;
               else if (pick < 97) r.op = OP_CLEAR_ALL;
               else                r.op = OP_W'($urandom_range(5, 7));
               r.addr = ($urandom_range(0, 9) == 0) ? rand_addr()
                                                    : addr_pool[$urandom_range(0, POOL_SIZE-1)];
               r.bssid = ($urandom_range(0, 3) == 0) ? rand_addr()
                                                     : bssid_pool[$urandom_range(0, 2)];
               r.mac = rand_mac();
               send_pred(r);
            end
         end else if (pick < 87) begin
            // refill from a random point in the pool
            send_pred(mk_req(OP_CLEAR_ALL, rand_addr(), rand_addr(), rand_mac()));
            base = $urandom_range(0, POOL_SIZE - 1);
            len  = SLOTS + $urandom_range(1, 4);
            for (int k = 0; k < len; k++)
               send_pred(mk_req(OP_ESTABLISH, addr_pool[(base + k) % POOL_SIZE],
                                bssid_pool[$urandom_range(0, 2)], rand_mac()));
         end else begin
            len = $urandom_range(4, 12);
            for (int k = 0; k < len; k++)
               send_pred(mk_req(OP_W'($urandom_range(0, 7)), rand_addr(), rand_addr(),
                                rand_mac()));
         end
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("sent %0d requests, checked %0d responses", n_sent, n_checked);
      $display("table-full refusals %0d, entries freed %0d, saturated counts %0d",
               n_full, n_freed, n_sat);
      if (mismatches == 0) begin
         $display("refcounted_peer_table_classifier regression: pass");
      end else begin
         $display("refcounted_peer_table_classifier regression: fail");
      end
      $finish;
   end

endmodule
